// ===== hw/rtl/lruc_pkg.sv =====
// ----------------------------------------------------------------------------
// lruc_pkg
// types, constants and codes shared by the lru cache controller and datapath
// ----------------------------------------------------------------------------
package lruc_pkg;

    localparam int CAPACITY   = 16;
    localparam int TAG_WIDTH  = 64;
    localparam int DATA_WIDTH = 64;
    localparam int TIME_WIDTH = 32;
    localparam int SLOT_W     = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int OUT_W      = 5;
    localparam int CFG_W      = 5;
    localparam int OP_W       = 3;

    localparam logic [OP_W-1:0] OP_LOOKUP = 3'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 3'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 3'd2;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd3;
    localparam logic [OP_W-1:0] OP_SWEEP  = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MATCH,
        ST_EVICT,
        ST_APPLY,
        ST_SWEEP,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic              load;
        logic              match;
        logic              evict;
        logic              apply;
        logic              sweep;
        logic [SLOT_W-1:0] sweep_idx;
    } cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            found;
    } status_t;

endpackage

// ===== hw/rtl/lruc_ctrl.sv =====
// ----------------------------------------------------------------------------
// lruc_ctrl
// sequencer: match, evict, apply or sweep over the slots, then report a beat
// ----------------------------------------------------------------------------
module lruc_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  lruc_pkg::status_t status,
    output lruc_pkg::cmd_t  cmd,
    output logic            busy,
    output logic            done
);
    import lruc_pkg::*;

    state_t            state_reg;
    state_t            state_next;
    logic [SLOT_W-1:0] idx_reg;
    logic [SLOT_W-1:0] idx_next;
    logic              idx_last;

    assign idx_last = (idx_reg == SLOT_W'(CAPACITY - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        case (state_reg)
            ST_IDLE:
            begin
                idx_next = '0;
                if (start)
                    state_next = ST_MATCH;
            end
            ST_MATCH:
            begin
                if (status.op == OP_SWEEP)
                    state_next = ST_SWEEP;
                else if (status.op == OP_INSERT && !status.found)
                    state_next = ST_EVICT;
                else
                    state_next = ST_APPLY;
            end
            ST_EVICT: state_next = ST_APPLY;
            ST_APPLY: state_next = ST_DONE;
            ST_SWEEP:
            begin
                idx_next = idx_reg + 1'b1;
                if (idx_last)
                    state_next = ST_DONE;
            end
            ST_DONE:  state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd           = '0;
        cmd.sweep_idx = idx_reg;
        busy          = 1'b1;
        done          = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            ST_MATCH: cmd.match = 1'b1;
            ST_EVICT: cmd.evict = 1'b1;
            ST_APPLY: cmd.apply = 1'b1;
            ST_SWEEP: cmd.sweep = 1'b1;
            ST_DONE:  done      = 1'b1;
            default:  busy      = 1'b1;
        endcase
    end

endmodule

// ===== hw/rtl/lruc_dp.sv =====
// ----------------------------------------------------------------------------
// lruc_dp
// entry storage, tag match, recency ranks, expiry and result registers
// ----------------------------------------------------------------------------
module lruc_dp (
    input  logic                             clk,
    input  logic                             rst_n,
    input  lruc_pkg::cmd_t                   cmd,
    output lruc_pkg::status_t                status,
    input  logic                             entry_cap_we,
    input  logic [lruc_pkg::CFG_W-1:0]       entry_cap,
    input  logic [lruc_pkg::OP_W-1:0]        opcode,
    input  logic [lruc_pkg::TAG_WIDTH-1:0]   key_tag,
    input  logic [lruc_pkg::DATA_WIDTH-1:0]  data_word,
    input  logic [lruc_pkg::TIME_WIDTH-1:0]  lifetime,
    input  logic [lruc_pkg::TIME_WIDTH-1:0]  current_time,
    output logic                             hit,
    output logic [lruc_pkg::DATA_WIDTH-1:0]  read_word,
    output logic [lruc_pkg::OUT_W-1:0]       removed_count,
    output logic [lruc_pkg::OUT_W-1:0]       occupancy
);
    import lruc_pkg::*;

    // control state
    logic [CAPACITY-1:0]   valid_reg, valid_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [CFG_W-1:0]      max_reg;
    logic [OP_W-1:0]       op_reg, op_next;
    logic                  found_reg, found_next;

    // payload
    logic [TAG_WIDTH-1:0]  tag_reg  [CAPACITY];
    logic [DATA_WIDTH-1:0] val_reg  [CAPACITY];
    logic [TIME_WIDTH-1:0] exp_reg  [CAPACITY];
    logic [SLOT_W-1:0]     rank_reg [CAPACITY];
    logic [SLOT_W-1:0]     rank_next[CAPACITY];
    logic [TAG_WIDTH-1:0]  key_reg;
    logic [DATA_WIDTH-1:0] data_reg;
    logic [TIME_WIDTH-1:0] life_reg;
    logic [TIME_WIDTH-1:0] now_reg;
    logic [SLOT_W-1:0]     slot_reg, slot_next;
    logic                  hit_reg, hit_next;
    logic [DATA_WIDTH-1:0] rd_reg, rd_next;
    logic [CNT_W-1:0]      rem_reg, rem_next;

    logic                  m_any, f_any;
    logic [SLOT_W-1:0]     m_slot, f_slot;
    logic [CNT_W-1:0]      limit, lim_m1;
    logic [TIME_WIDTH:0]   exp_sum;
    logic [TIME_WIDTH-1:0] exp_new;
    logic [SLOT_W-1:0]     sel_rank, sw_rank;
    logic                  sw_drop;
    logic                  wr_en;
    logic [SLOT_W-1:0]     wr_slot;

    assign status.op    = op_reg;
    assign status.found = m_any;

    assign hit           = hit_reg;
    assign read_word     = rd_reg;
    assign removed_count = OUT_W'(rem_reg);
    assign occupancy     = OUT_W'(count_reg);

    always_comb
    begin
        m_any  = 1'b0;
        m_slot = '0;
        f_any  = 1'b0;
        f_slot = '0;
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            if (valid_reg[i] && tag_reg[i] == key_reg)
            begin
                m_any  = 1'b1;
                m_slot = SLOT_W'(i);
            end
            if (!valid_reg[i])
            begin
                f_any  = 1'b1;
                f_slot = SLOT_W'(i);
            end
        end
    end

    always_comb
    begin
        if (max_reg == '0)
            limit = CNT_W'(1);
        else if (32'(max_reg) > CAPACITY)
            limit = CNT_W'(CAPACITY);
        else
            limit = CNT_W'(max_reg);
        lim_m1 = limit - 1'b1;
    end

    // saturating expiry
    assign exp_sum  = {1'b0, now_reg} + {1'b0, life_reg};
    assign exp_new  = exp_sum[TIME_WIDTH] ? '1 : exp_sum[TIME_WIDTH-1:0];
    assign sel_rank = rank_reg[slot_reg];
    assign sw_rank  = rank_reg[cmd.sweep_idx];
    assign sw_drop  = valid_reg[cmd.sweep_idx] && (exp_reg[cmd.sweep_idx] <= now_reg);

    always_comb
    begin
        valid_next = valid_reg;
        count_next = count_reg;
        op_next    = op_reg;
        found_next = found_reg;
        slot_next  = slot_reg;
        hit_next   = hit_reg;
        rd_next    = rd_reg;
        rem_next   = rem_reg;
        wr_en      = 1'b0;
        wr_slot    = slot_reg;
        for (int i = 0; i < CAPACITY; i++)
            rank_next[i] = rank_reg[i];

        if (cmd.load)
        begin
            op_next  = opcode;
            hit_next = 1'b0;
            rd_next  = '0;
            rem_next = '0;
        end

        if (cmd.match)
        begin
            found_next = m_any;
            slot_next  = m_slot;
        end

        if (cmd.evict && count_reg >= limit)
        begin
            for (int i = 0; i < CAPACITY; i++)
                if (valid_reg[i] && CNT_W'(rank_reg[i]) >= lim_m1)
                    valid_next[i] = 1'b0;
            count_next = lim_m1;
            rem_next   = count_reg - lim_m1;
        end

        if (cmd.apply)
        begin
            case (op_reg)
                OP_LOOKUP:
                begin
                    if (found_reg)
                    begin
                        hit_next = 1'b1;
                        rd_next  = val_reg[slot_reg];
                        for (int i = 0; i < CAPACITY; i++)
                            if (valid_reg[i] && rank_reg[i] < sel_rank)
                                rank_next[i] = rank_reg[i] + 1'b1;
                        rank_next[slot_reg] = '0;
                    end
                end
                OP_INSERT:
                begin
                    if (found_reg)
                    begin
                        wr_en = 1'b1;
                        for (int i = 0; i < CAPACITY; i++)
                            if (valid_reg[i] && rank_reg[i] < sel_rank)
                                rank_next[i] = rank_reg[i] + 1'b1;
                        rank_next[slot_reg] = '0;
                    end
                    else if (f_any)
                    begin
                        wr_en   = 1'b1;
                        wr_slot = f_slot;
                        for (int i = 0; i < CAPACITY; i++)
                            if (valid_reg[i])
                                rank_next[i] = rank_reg[i] + 1'b1;
                        rank_next[f_slot]  = '0;
                        valid_next[f_slot] = 1'b1;
                        count_next         = count_reg + 1'b1;
                    end
                end
                OP_REMOVE:
                begin
                    if (found_reg)
                    begin
                        valid_next[slot_reg] = 1'b0;
                        for (int i = 0; i < CAPACITY; i++)
                            if (valid_reg[i] && rank_reg[i] > sel_rank)
                                rank_next[i] = rank_reg[i] - 1'b1;
                        count_next = count_reg - 1'b1;
                        rem_next   = CNT_W'(1);
                    end
                end
                OP_CLEAR:
                begin
                    rem_next   = count_reg;
                    valid_next = '0;
                    count_next = '0;
                end
                default: ;
            endcase
        end

        if (cmd.sweep && sw_drop)
        begin
            valid_next[cmd.sweep_idx] = 1'b0;
            for (int i = 0; i < CAPACITY; i++)
                if (valid_reg[i] && rank_reg[i] > sw_rank)
                    rank_next[i] = rank_reg[i] - 1'b1;
            count_next = count_reg - 1'b1;
            rem_next   = rem_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            count_reg <= '0;
            max_reg   <= CFG_W'(CAPACITY);
            op_reg    <= '0;
            found_reg <= 1'b0;
            hit_reg   <= 1'b0;
            rem_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            count_reg <= count_next;
            op_reg    <= op_next;
            found_reg <= found_next;
            hit_reg   <= hit_next;
            rem_reg   <= rem_next;
            if (entry_cap_we)
                max_reg <= entry_cap;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_reg  <= key_tag;
            data_reg <= data_word;
            life_reg <= lifetime;
            now_reg  <= current_time;
        end
        slot_reg <= slot_next;
        rd_reg   <= rd_next;
        for (int i = 0; i < CAPACITY; i++)
            rank_reg[i] <= rank_next[i];
        if (wr_en)
        begin
            tag_reg[wr_slot] <= key_reg;
            val_reg[wr_slot] <= data_reg;
            exp_reg[wr_slot] <= exp_new;
        end
    end

endmodule

// ===== hw/rtl/lru_cache_with_expiry_core.sv =====
// ----------------------------------------------------------------------------
// lru_cache_with_expiry_core
// fully associative lru cache with per-entry expiry, one result beat per item
// ----------------------------------------------------------------------------
// sequence: lookup, remove, clear and update pass through match and apply before done,
//   insert of a new key also through evict, sweep through all slots (one slot per cycle)
// throughput: one item at a time; busy stays high until the done beat
// the receiver cannot stall; done is high for exactly one cycle
// reset: all entries invalid, occupancy 0, entry_cap 16
module lru_cache_with_expiry_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             entry_cap_we,
    input  logic [lruc_pkg::CFG_W-1:0]       entry_cap,
    input  logic                             start,
    output logic                             busy,
    input  logic [lruc_pkg::OP_W-1:0]        opcode,
    input  logic [lruc_pkg::TAG_WIDTH-1:0]   key_tag,
    input  logic [lruc_pkg::DATA_WIDTH-1:0]  data_word,
    input  logic [lruc_pkg::TIME_WIDTH-1:0]  lifetime,
    input  logic [lruc_pkg::TIME_WIDTH-1:0]  current_time,
    output logic                             done,
    output logic                             hit,
    output logic [lruc_pkg::DATA_WIDTH-1:0]  read_word,
    output logic [lruc_pkg::OUT_W-1:0]       removed_count,
    output logic [lruc_pkg::OUT_W-1:0]       occupancy
);
    import lruc_pkg::*;

    cmd_t    cmd;
    status_t status;

    lruc_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    lruc_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .entry_cap_we   (entry_cap_we),
        .entry_cap      (entry_cap),
        .opcode         (opcode),
        .key_tag        (key_tag),
        .data_word      (data_word),
        .lifetime       (lifetime),
        .current_time   (current_time),
        .hit            (hit),
        .read_word      (read_word),
        .removed_count  (removed_count),
        .occupancy      (occupancy)
    );

endmodule

// ===== tb/sv/lru_cache_with_expiry_checker.sv =====
// ----------------------------------------------------------------------------
// lru_cache_with_expiry_checker
// watches the config port, the command beats and the result beats of the
// lru cache; keeps its own copy of the cache, predicts every result and
// compares it field by field with the result beat that comes back
// ----------------------------------------------------------------------------
module lru_cache_with_expiry_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            entry_cap_we,
    input  logic [lruc_pkg::CFG_W-1:0]      entry_cap,
    input  logic                            start,
    input  logic                            busy,
    input  logic [lruc_pkg::OP_W-1:0]       opcode,
    input  logic [lruc_pkg::TAG_WIDTH-1:0]  key_tag,
    input  logic [lruc_pkg::DATA_WIDTH-1:0] data_word,
    input  logic [lruc_pkg::TIME_WIDTH-1:0] lifetime,
    input  logic [lruc_pkg::TIME_WIDTH-1:0] current_time,
    input  logic                            done,
    input  logic                            hit,
    input  logic [lruc_pkg::DATA_WIDTH-1:0] read_word,
    input  logic [lruc_pkg::OUT_W-1:0]      removed_count,
    input  logic [lruc_pkg::OUT_W-1:0]      occupancy,
    output int                              fail_count,
    output int                              pending,
    output int                              hit_count
);
    import lruc_pkg::*;

    typedef struct packed {
        logic                  hit;
        logic [DATA_WIDTH-1:0] word;
        logic [OUT_W-1:0]      removed;
        logic [OUT_W-1:0]      occ;
    } outcome_t;

    logic                  line_valid [CAPACITY];
    logic [TAG_WIDTH-1:0]  line_tag   [CAPACITY];
    logic [DATA_WIDTH-1:0] line_value [CAPACITY];
    logic [TIME_WIDTH-1:0] line_exp   [CAPACITY];
    int                    line_rank  [CAPACITY];
    int                    live_lines;
    int                    keep_limit;
    outcome_t              awaited [$];

    function automatic int slot_of(input logic [TAG_WIDTH-1:0] tag);
        for (int i = 0; i < CAPACITY; i++)
            if (line_valid[i] && line_tag[i] == tag)
                return i;
        return -1;
    endfunction

    function automatic void promote(input int s);
        int r;
        r = line_rank[s];
        for (int i = 0; i < CAPACITY; i++)
            if (line_valid[i] && line_rank[i] < r)
                line_rank[i]++;
        line_rank[s] = 0;
    endfunction

    function automatic void drop_line(input int s);
        int r;
        r = line_rank[s];
        line_valid[s] = 1'b0;
        for (int i = 0; i < CAPACITY; i++)
            if (line_valid[i] && line_rank[i] > r)
                line_rank[i]--;
        live_lines--;
    endfunction

    function automatic logic [TIME_WIDTH-1:0] expiry_at(input logic [TIME_WIDTH-1:0] now,
                                                        input logic [TIME_WIDTH-1:0] life);
        logic [TIME_WIDTH:0] sum;
        sum = {1'b0, now} + {1'b0, life};
        return sum[TIME_WIDTH] ? '1 : sum[TIME_WIDTH-1:0];
    endfunction

    function automatic outcome_t cache_step(input logic [OP_W-1:0] op,
                                            input logic [TAG_WIDTH-1:0] tag,
                                            input logic [DATA_WIDTH-1:0] data,
                                            input logic [TIME_WIDTH-1:0] life,
                                            input logic [TIME_WIDTH-1:0] now);
        outcome_t o;
        int       lim;
        int       s;
        int       v;
        int       dropped;
        o       = '0;
        dropped = 0;
        lim     = (keep_limit < 1) ? 1 : (keep_limit > CAPACITY) ? CAPACITY : keep_limit;
        case (op)
            OP_LOOKUP:
            begin
                s = slot_of(tag);
                if (s >= 0)
                begin
                    o.hit  = 1'b1;
                    o.word = line_value[s];
                    promote(s);
                end
            end
            OP_INSERT:
            begin
                s = slot_of(tag);
                if (s >= 0)
                begin
                    line_value[s] = data;
                    line_exp[s]   = expiry_at(now, life);
                    promote(s);
                end
                else
                begin
                    while (live_lines >= lim)
                    begin
                        v = -1;
                        for (int i = 0; i < CAPACITY; i++)
                            if (v < 0 && line_valid[i] && line_rank[i] == live_lines - 1)
                                v = i;
                        if (v < 0)
                            break;
                        drop_line(v);
                        dropped++;
                    end
                    s = -1;
                    for (int i = 0; i < CAPACITY; i++)
                        if (s < 0 && !line_valid[i])
                            s = i;
                    if (s >= 0)
                    begin
                        for (int i = 0; i < CAPACITY; i++)
                            if (line_valid[i])
                                line_rank[i]++;
                        line_valid[s] = 1'b1;
                        line_tag[s]   = tag;
                        line_value[s] = data;
                        line_exp[s]   = expiry_at(now, life);
                        line_rank[s]  = 0;
                        live_lines++;
                    end
                end
            end
            OP_REMOVE:
            begin
                s = slot_of(tag);
                if (s >= 0)
                begin
                    drop_line(s);
                    dropped = 1;
                end
            end
            OP_CLEAR:
            begin
                dropped = live_lines;
                for (int i = 0; i < CAPACITY; i++)
                    line_valid[i] = 1'b0;
                live_lines = 0;
            end
            OP_SWEEP:
            begin
                for (int i = 0; i < CAPACITY; i++)
                    if (line_valid[i] && line_exp[i] <= now)
                    begin
                        drop_line(i);
                        dropped++;
                    end
            end
            default:
            begin
            end
        endcase
        o.removed = dropped[OUT_W-1:0];
        o.occ     = live_lines[OUT_W-1:0];
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        outcome_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < CAPACITY; i++)
            begin
                line_valid[i] = 1'b0;
                line_rank[i]  = 0;
            end
            live_lines = 0;
            keep_limit = 16;
            awaited.delete();
            pending    = 0;
            fail_count <= 0;
            hit_count  <= 0;
        end
        else
        begin
            if (done)
            begin
                if (awaited.size() == 0)
                begin
                    $error("result beat with nothing outstanding");
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = awaited.pop_front();
                    if (want.hit)
                        hit_count <= hit_count + 1;
                    if (hit !== want.hit)
                    begin
                        $error("hit: expected %0d, got %0d", want.hit, hit);
                        fail_count <= fail_count + 1;
                    end
                    if (read_word !== want.word)
                    begin
                        $error("read_word: expected %h, got %h", want.word, read_word);
                        fail_count <= fail_count + 1;
                    end
                    if (removed_count !== want.removed)
                    begin
                        $error("removed_count: expected %0d, got %0d",
                               want.removed, removed_count);
                        fail_count <= fail_count + 1;
                    end
                    if (occupancy !== want.occ)
                    begin
                        $error("occupancy: expected %0d, got %0d", want.occ, occupancy);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (entry_cap_we)
                keep_limit = int'(entry_cap);
            if (start && !busy)
                awaited.push_back(cache_step(opcode, key_tag, data_word, lifetime,
                                             current_time));
            pending = awaited.size();
        end
    end

endmodule

// ===== tb/sv/lru_cache_with_expiry_core_test.sv =====
// ----------------------------------------------------------------------------
// lru_cache_with_expiry_core_test
// drives directed and random command beats and entry limit settings into the
// lru cache with random gaps; the checker predicts and compares the results
// ----------------------------------------------------------------------------
module lru_cache_with_expiry_core_test;
    import lruc_pkg::*;

    localparam int IDLE_LIMIT = 4000;
    localparam int SETTLE     = 25;
    localparam int PHASE_LEN  = 120;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  entry_cap_we = 1'b0;
    logic [CFG_W-1:0]      entry_cap = '0;
    logic                  start = 1'b0;
    logic                  busy;
    logic [OP_W-1:0]       opcode = '0;
    logic [TAG_WIDTH-1:0]  key_tag = '0;
    logic [DATA_WIDTH-1:0] data_word = '0;
    logic [TIME_WIDTH-1:0] lifetime = '0;
    logic [TIME_WIDTH-1:0] current_time = '0;
    logic                  done;
    logic                  hit;
    logic [DATA_WIDTH-1:0] read_word;
    logic [OUT_W-1:0]      removed_count;
    logic [OUT_W-1:0]      occupancy;
    int                    fail_count;
    int                    pending;
    int                    hit_count;

    int                    idle_cycles = 0;
    int                    beats_sent = 0;
    int                    settings_used = 0;
    logic [TAG_WIDTH-1:0]  key_pool [24];
    logic [TIME_WIDTH-1:0] tick = '0;

    always #1 clk = ~clk;

    lru_cache_with_expiry_core DUT (
        .clk(clk), .rst_n(rst_n), .entry_cap_we(entry_cap_we),
        .entry_cap(entry_cap), .start(start), .busy(busy), .opcode(opcode),
        .key_tag(key_tag), .data_word(data_word), .lifetime(lifetime),
        .current_time(current_time), .done(done), .hit(hit), .read_word(read_word),
        .removed_count(removed_count), .occupancy(occupancy)
    );

    lru_cache_with_expiry_checker u_checker (
        .clk(clk), .rst_n(rst_n), .entry_cap_we(entry_cap_we),
        .entry_cap(entry_cap), .start(start), .busy(busy), .opcode(opcode),
        .key_tag(key_tag), .data_word(data_word), .lifetime(lifetime),
        .current_time(current_time), .done(done), .hit(hit), .read_word(read_word),
        .removed_count(removed_count), .occupancy(occupancy),
        .fail_count(fail_count), .pending(pending), .hit_count(hit_count)
    );

    always @(posedge clk)
    begin
        if ((start && !busy) || done || entry_cap_we || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send(input logic [OP_W-1:0] op, input logic [TAG_WIDTH-1:0] tag,
                        input logic [DATA_WIDTH-1:0] data, input logic [TIME_WIDTH-1:0] life,
                        input logic [TIME_WIDTH-1:0] now, input int gap);
        opcode       <= op;
        key_tag      <= tag;
        data_word    <= data;
        lifetime     <= life;
        current_time <= now;
        start        <= 1'b1;
        @(negedge clk);
        while (busy)
            @(negedge clk);
        @(posedge clk);
        beats_sent++;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic set_limit(input logic [CFG_W-1:0] value);
        start <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE) @(posedge clk);
        entry_cap_we <= 1'b1;
        entry_cap    <= value;
        @(posedge clk);
        entry_cap_we <= 1'b0;
        settings_used++;
    endtask

    task automatic random_beat();
        int                    r;
        logic [OP_W-1:0]       op;
        logic [TAG_WIDTH-1:0]  tag;
        logic [TIME_WIDTH-1:0] life;
        logic [TIME_WIDTH-1:0] now;
        r = $urandom_range(0, 99);
        if (r < 35)
            op = OP_LOOKUP;
        else if (r < 75)
            op = OP_INSERT;
        else if (r < 85)
            op = OP_REMOVE;
        else if (r < 87)
            op = OP_CLEAR;
        else if (r < 97)
            op = OP_SWEEP;
        else
            op = OP_SWEEP + OP_W'($urandom_range(1, 3));
        if ($urandom_range(0, 99) < 85)
            tag = key_pool[$urandom_range(0, 23)];
        else
            tag = {$urandom, $urandom};
        tick = tick + $urandom_range(0, 4);
        now  = tick;
        r    = $urandom_range(0, 99);
        if (r < 80)
            life = $urandom_range(0, 60);
        else if (r < 92)
            life = $urandom;
        else
            life = '1;
        if ($urandom_range(0, 99) < 3)
            now = $urandom;
        send(op, tag, {$urandom, $urandom}, life, now, pick_gap());
    endtask

    initial
    begin
        logic [CFG_W-1:0] plan [12];
        plan = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd3, 5'd8, 5'd16, 5'd2, 5'd12, 5'd17, 5'd5, 5'd15};
        for (int i = 0; i < 24; i++)
            key_pool[i] = {$urandom, $urandom};
        key_pool[0] = '0;
        key_pool[1] = '1;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty miss, extremes, overflow expiry, update, sweeps, removes
        send(OP_LOOKUP, key_pool[0], '0, '0, '0, 0);
        send(OP_INSERT, key_pool[1], '1, '1, '1, 1);
        send(OP_INSERT, key_pool[0], '0, '0, '0, 0);
        send(OP_LOOKUP, key_pool[1], '0, '0, '0, 0);
        send(OP_INSERT, key_pool[1], 64'h5a5a_a5a5_0f0f_f0f0, 32'd10, 32'd5, 2);
        send(OP_LOOKUP, key_pool[1], '0, '0, '0, 0);
        send(OP_SWEEP, '0, '0, '0, 32'd0, 0);
        send(OP_SWEEP, '0, '0, '0, 32'd15, 0);
        send(OP_REMOVE, key_pool[2], '0, '0, '0, 0);
        send(OP_INSERT, key_pool[2], 64'h1, 32'd3, 32'd1, 0);
        send(OP_INSERT, key_pool[3], 64'h2, 32'd3, 32'd1, 0);
        send(OP_INSERT, key_pool[4], 64'h3, 32'd3, 32'd1, 0);
        send(OP_REMOVE, key_pool[3], '0, '0, '0, 0);
        send(OP_SWEEP + 3'd1, '0, '0, '0, '0, 0);

        foreach (plan[p])
        begin
            set_limit(plan[p]);
            repeat (PHASE_LEN)
                random_beat();
        end

        start <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(posedge clk);
        $display("tb: %0d command beats over %0d entry limit settings, %0d lookup hits",
                 beats_sent, settings_used, hit_count);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
